// ===== rtl/core/lcgg_pkg.sv =====
// Shared types, constant activation tables and fixed-point helpers for the LSTM gradient core.
package lcgg_pkg;

  localparam int ACT_TABLE_BITS = 10;
  localparam int TAB_SIZE       = 1 << ACT_TABLE_BITS;
  localparam int EXP_BITS       = 17;
  localparam int Q_ONE          = 4096;
  localparam int NSTAGE         = 6;

  typedef logic signed [15:0] q12_t;
  typedef logic signed [16:0] q12w_t;
  // activations lie in [-1.0, 1.0] inclusive
  typedef logic signed [13:0] act_t;
  typedef logic [ACT_TABLE_BITS-1:0] tab_idx_t;
  typedef logic [TAB_SIZE-1:0][13:0] act_tab_t;

  typedef struct packed {
    q12_t in_gate;
    q12_t forget_gate;
    q12_t cand_gate;
    q12_t out_gate;
    q12_t cell_new;
  } gate_pre_t;

  typedef struct packed {
    act_t in_gate;
    act_t forget_gate;
    act_t cand_gate;
    act_t out_gate;
    act_t cell_tanh;
  } gate_act_t;

  localparam q12w_t Q_ONE_W = 17'sd4096;

  // Elaboration-time helpers for building the tables
  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] neg_exp(input logic [EXP_BITS-1:0] a);
    logic [63:0] r;
    logic [63:0] e;
    r = 64'd1 << 30;
    e = (64'd1 << 30) - (64'd1 << 18) + 64'd32;
    for (int j = 0; j < EXP_BITS; j++) begin
      if (a[j]) r = q30_mul(r, e);
      e = q30_mul(e, e);
    end
    return r;
  endfunction

  // restoring shift-subtract quotient
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic int bin_mid(input int k);
    return ((k << (16 - ACT_TABLE_BITS)) | (1 << (15 - ACT_TABLE_BITS))) - 32768;
  endfunction

  function automatic act_tab_t build_sig();
    act_tab_t tab;
    int x;
    int s;
    logic [EXP_BITS-1:0] a;
    logic [63:0] den;
    tab = '0;
    for (int k = 0; k < TAB_SIZE; k++) begin
      x   = bin_mid(k);
      a   = EXP_BITS'(x < 0 ? -x : x);
      den = (64'd1 << 30) + neg_exp(a);
      s   = int'(udiv((64'd1 << 42) + (den >> 1), den));
      tab[k] = 14'(x < 0 ? Q_ONE - s : s);
    end
    return tab;
  endfunction

  function automatic act_tab_t build_tanh();
    act_tab_t tab;
    int x;
    int t;
    logic [EXP_BITS-1:0] a;
    logic [63:0] e2;
    logic [63:0] den;
    tab = '0;
    for (int k = 0; k < TAB_SIZE; k++) begin
      x   = bin_mid(k);
      a   = EXP_BITS'(x < 0 ? -x : x);
      e2  = neg_exp(EXP_BITS'({a, 1'b0}));
      den = (64'd1 << 30) + e2;
      t   = int'(udiv(64'(Q_ONE) * ((64'd1 << 30) - e2) + (den >> 1), den));
      tab[k] = 14'(x < 0 ? -t : t);
    end
    return tab;
  endfunction

  localparam act_tab_t SIG_TAB  = build_sig();
  localparam act_tab_t TANH_TAB = build_tanh();

  // Datapath helpers
  function automatic tab_idx_t tab_index(input q12_t raw);
    logic [15:0] u;
    u = raw ^ 16'h8000;
    return u[15 -: ACT_TABLE_BITS];
  endfunction

  function automatic q12w_t wide_q(input q12_t v);
    return {v[15], v};
  endfunction

  function automatic q12w_t wide_a(input act_t v);
    return {{3{v[13]}}, v};
  endfunction

  function automatic q12_t sat16(input q12w_t v);
    if (v > 17'sd32767) return 16'sh7FFF;
    if (v < -17'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Q12 product, round half up, saturate
  function automatic q12_t qmul(input q12w_t a, input q12w_t b);
    logic signed [33:0] p;
    logic signed [21:0] s;
    p = a * b + 34'sd2048;
    s = p[33:12];
    if (s > 22'sd32767) return 16'sh7FFF;
    if (s < -22'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

endpackage

// ===== rtl/core/lcgg_in_if.sv =====
// Input channel: valid/ready handshake with the nine cell operands.
interface lcgg_in_if import lcgg_pkg::*; ();
  logic valid;
  logic ready;
  q12_t out_grad;
  q12_t hid_carry;
  q12_t cell_carry;
  q12_t in_gate_pre;
  q12_t forget_gate_pre;
  q12_t cand_gate_pre;
  q12_t out_gate_pre;
  q12_t cell_new;
  q12_t cell_old;

  modport source (
    output valid, out_grad, hid_carry, cell_carry, in_gate_pre, forget_gate_pre,
           cand_gate_pre, out_gate_pre, cell_new, cell_old,
    input  ready
  );
  modport sink (
    input  valid, out_grad, hid_carry, cell_carry, in_gate_pre, forget_gate_pre,
           cand_gate_pre, out_gate_pre, cell_new, cell_old,
    output ready
  );
endinterface

// ===== rtl/core/lcgg_out_if.sv =====
// Output channel: valid/ready handshake with the four gate gradients and the carried cell gradient.
interface lcgg_out_if import lcgg_pkg::*; ();
  logic valid;
  logic ready;
  q12_t in_gate_grad;
  q12_t forget_gate_grad;
  q12_t cand_gate_grad;
  q12_t out_gate_grad;
  q12_t cell_carry_out;

  modport source (
    output valid, in_gate_grad, forget_gate_grad, cand_gate_grad, out_gate_grad,
           cell_carry_out,
    input  ready
  );
  modport sink (
    input  valid, in_gate_grad, forget_gate_grad, cand_gate_grad, out_gate_grad,
           cell_carry_out,
    output ready
  );
endinterface

// ===== rtl/core/lcgg_act_lut.sv =====
// Registered sigmoid and tanh table lookups for the four gates and the new cell value.
module lcgg_act_lut import lcgg_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  gate_pre_t pre,
  output gate_act_t act
);

  always_ff @(posedge clk) begin
    if (en) begin
      act.in_gate     <= $signed(SIG_TAB[tab_index(pre.in_gate)]);
      act.forget_gate <= $signed(SIG_TAB[tab_index(pre.forget_gate)]);
      act.cand_gate   <= $signed(TANH_TAB[tab_index(pre.cand_gate)]);
      act.out_gate    <= $signed(SIG_TAB[tab_index(pre.out_gate)]);
      act.cell_tanh   <= $signed(TANH_TAB[tab_index(pre.cell_new)]);
    end
  end

endmodule

// ===== rtl/core/lstm_cell_gate_gradient_core.sv =====
// LSTM backward cell kernel: gate pre-activation gradients and carried cell gradient per request.
//
//  channel  dir  handshake     payload
//  item     in   valid/ready   out_grad .. cell_old, nine Q3.12 operands
//  result   out  valid/ready   in/forget/cand/out gate gradients, cell_carry_out
//
// Six register stages: table lookup and hidden sum, gate products, output-gate
// gradient and cell term, cell gradient sum, cell gradient products, final products.
// One request per cycle unless the result stalls; the result leaves the sixth stage.
// Synchronous reset clears the stage valid bits only.
// A stalled result freezes the whole pipe; ready follows the last stage.
module lstm_cell_gate_gradient_core import lcgg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lcgg_in_if.sink      item,
  lcgg_out_if.source   result
);

  logic              en;
  logic [NSTAGE-1:0] v;

  gate_pre_t pre;
  gate_act_t act;

  // stage 1
  q12_t dh1, cc1, co1;
  // stage 2
  q12_t  p_dh_tc2, p_oo2, p_dh_o2, p_ff2, p_ii2;
  q12w_t om_tc2, om_g2;
  act_t  ig2, fg2, gg2;
  q12_t  cc2, co2;
  // stage 3
  q12_t  do3, t3, p_ff3, p_ii3, cc3, co3;
  q12w_t om_g3;
  act_t  ig3, fg3, gg3;
  // stage 4
  q12_t  do4, dc4, p_ff4, p_ii4, co4;
  q12w_t om_g4;
  act_t  ig4, fg4, gg4;
  // stage 5
  q12_t  do5, a5, b5, c5, cco5, p_ff5, p_ii5;
  q12w_t om_g5;
  // stage 6
  q12_t  di6, df6, dg6, do6, cco6;

  assign en         = !v[NSTAGE-1] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NSTAGE-2:0], item.valid};
    end
  end

  assign pre.in_gate     = item.in_gate_pre;
  assign pre.forget_gate = item.forget_gate_pre;
  assign pre.cand_gate   = item.cand_gate_pre;
  assign pre.out_gate    = item.out_gate_pre;
  assign pre.cell_new    = item.cell_new;

  lcgg_act_lut u_lut (
    .clk (clk),
    .en  (en),
    .pre (pre),
    .act (act)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dh1 <= sat16(wide_q(item.out_grad) + wide_q(item.hid_carry));
      cc1 <= item.cell_carry;
      co1 <= item.cell_old;

      p_dh_tc2 <= qmul(wide_q(dh1), wide_a(act.cell_tanh));
      p_oo2    <= qmul(wide_a(act.out_gate), Q_ONE_W - wide_a(act.out_gate));
      p_dh_o2  <= qmul(wide_q(dh1), wide_a(act.out_gate));
      om_tc2   <= Q_ONE_W - wide_q(qmul(wide_a(act.cell_tanh), wide_a(act.cell_tanh)));
      p_ff2    <= qmul(wide_a(act.forget_gate), Q_ONE_W - wide_a(act.forget_gate));
      p_ii2    <= qmul(wide_a(act.in_gate), Q_ONE_W - wide_a(act.in_gate));
      om_g2    <= Q_ONE_W - wide_q(qmul(wide_a(act.cand_gate), wide_a(act.cand_gate)));
      ig2      <= act.in_gate;
      fg2      <= act.forget_gate;
      gg2      <= act.cand_gate;
      cc2      <= cc1;
      co2      <= co1;

      do3   <= qmul(wide_q(p_dh_tc2), wide_q(p_oo2));
      t3    <= qmul(wide_q(p_dh_o2), om_tc2);
      p_ff3 <= p_ff2;
      p_ii3 <= p_ii2;
      om_g3 <= om_g2;
      ig3   <= ig2;
      fg3   <= fg2;
      gg3   <= gg2;
      cc3   <= cc2;
      co3   <= co2;

      do4   <= do3;
      dc4   <= sat16(wide_q(t3) + wide_q(cc3));
      p_ff4 <= p_ff3;
      p_ii4 <= p_ii3;
      om_g4 <= om_g3;
      ig4   <= ig3;
      fg4   <= fg3;
      gg4   <= gg3;
      co4   <= co3;

      do5   <= do4;
      a5    <= qmul(wide_q(dc4), wide_q(co4));
      b5    <= qmul(wide_q(dc4), wide_a(gg4));
      c5    <= qmul(wide_q(dc4), wide_a(ig4));
      cco5  <= qmul(wide_q(dc4), wide_a(fg4));
      p_ff5 <= p_ff4;
      p_ii5 <= p_ii4;
      om_g5 <= om_g4;

      df6  <= qmul(wide_q(a5), wide_q(p_ff5));
      di6  <= qmul(wide_q(b5), wide_q(p_ii5));
      dg6  <= qmul(wide_q(c5), om_g5);
      do6  <= do5;
      cco6 <= cco5;
    end
  end

  assign result.valid            = v[NSTAGE-1];
  assign result.in_gate_grad     = di6;
  assign result.forget_gate_grad = df6;
  assign result.cand_gate_grad   = dg6;
  assign result.out_gate_grad    = do6;
  assign result.cell_carry_out   = cco6;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> v[0])
    else $error("accepted request did not enter the first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("stage valid bits moved during a stall");

  a_back: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !item.ready)
    else $error("request taken while the result is held");

  a_reset: assert property (@(posedge clk)
    rst |=> v == '0)
    else $error("stage valid bits not cleared by reset");

endmodule
